[sv/tfd_pkg.sv]
// Shared types, codes and constants for the tunnel frame deframer.
`default_nettype none

package tfd_pkg;

  // Result kinds carried on the master-side tuser
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_KEEP  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Frame type bytes
  localparam logic [7:0] TYPE_KEEPALIVE = 8'd1;
  localparam logic [7:0] TYPE_PACKET    = 8'd3;

  // Frame geometry
  localparam logic [15:0] MIN_PACKET = 16'd28;
  localparam logic [15:0] HDR_LEN    = 16'd14;
  localparam logic [7:0]  SLOT_SIZE  = 8'd6;

  // Configuration register indexes and reset values
  localparam logic CFG_PROTOCOL_ID = 1'b0;
  localparam logic CFG_INSTANCE_ID = 1'b1;
  localparam logic [15:0] PROTOCOL_ID_RESET = 16'hE78A;
  localparam logic [15:0] INSTANCE_ID_RESET = 16'hDEFA;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[sv/tfd_parser.sv]
// Frame parser: phase register, counters and header check for one byte per cycle when a beat is accepted.
`default_nettype none

module tfd_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             beat,
  input  wire logic             mode,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [15:0]      protocol_id,
  input  wire logic [15:0]      instance_id,
  output logic                  res_valid,
  output tfd_pkg::result_t      res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LENHI  = 3'd1;
  localparam logic [2:0] PH_LENLO  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_HEADER = 3'd4;
  localparam logic [2:0] PH_FWD    = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  logic [2:0]  phase, phase_next;
  logic        frame_is_packet, frame_is_packet_next;
  logic [15:0] frame_length, frame_length_next;
  logic [3:0]  byte_index, byte_index_next;
  logic        header_match, header_match_next;
  logic [15:0] inner_length, inner_length_next;
  logic [15:0] payload_left, payload_left_next;

  logic [15:0] len_full;
  logic [15:0] rest;
  logic [15:0] inner_full;
  logic [15:0] left_dec;
  logic [7:0]  expected;

  assign len_full   = {frame_length[15:8], rx_byte};
  assign rest       = frame_length - tfd_pkg::HDR_LEN;
  assign inner_full = {inner_length[15:8], rx_byte};
  assign left_dec   = payload_left - 16'd1;

  // Expected inner header byte at the current position
  always_comb begin
    unique case (byte_index)
      4'd0:    expected = protocol_id[15:8];
      4'd1:    expected = protocol_id[7:0];
      4'd2:    expected = instance_id[15:8];
      4'd3:    expected = instance_id[7:0];
      4'd7, 4'd9, 4'd11: expected = tfd_pkg::SLOT_SIZE;
      default: expected = 8'd0;
    endcase
  end

  // Next state and result for the beat
  always_comb begin
    phase_next           = phase;
    frame_is_packet_next = frame_is_packet;
    frame_length_next    = frame_length;
    byte_index_next      = byte_index;
    header_match_next    = header_match;
    inner_length_next    = inner_length;
    payload_left_next    = payload_left;
    res_valid            = 1'b0;
    res.kind             = tfd_pkg::KIND_DATA;
    res.payload_byte     = 8'd0;
    res.last             = 1'b0;

    if (beat) begin
      if (mode) begin
        phase_next           = PH_IDLE;
        frame_is_packet_next = 1'b0;
        frame_length_next    = 16'd0;
        byte_index_next      = 4'd0;
        header_match_next    = 1'b1;
        inner_length_next    = 16'd0;
        payload_left_next    = 16'd0;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            if (rx_byte == tfd_pkg::TYPE_KEEPALIVE || rx_byte == tfd_pkg::TYPE_PACKET) begin
              frame_is_packet_next = (rx_byte == tfd_pkg::TYPE_PACKET);
              phase_next           = PH_LENHI;
            end else begin
              phase_next = PH_ERROR;
              res_valid  = 1'b1;
              res.kind   = tfd_pkg::KIND_ERROR;
            end
          end
          PH_LENHI: begin
            frame_length_next = {rx_byte, 8'd0};
            phase_next        = PH_LENLO;
          end
          PH_LENLO: begin
            frame_length_next = len_full;
            if (!frame_is_packet || len_full < tfd_pkg::MIN_PACKET) begin
              // keepalive or short packet: skip the payload
              payload_left_next = len_full;
              phase_next        = (len_full == 16'd0) ? PH_IDLE : PH_SKIP;
              if (!frame_is_packet) begin
                res_valid = 1'b1;
                res.kind  = tfd_pkg::KIND_KEEP;
              end
            end else begin
              byte_index_next   = 4'd0;
              header_match_next = 1'b1;
              inner_length_next = 16'd0;
              phase_next        = PH_HEADER;
            end
          end
          PH_SKIP: begin
            payload_left_next = left_dec;
            if (left_dec == 16'd0) phase_next = PH_IDLE;
          end
          PH_HEADER: begin
            byte_index_next = byte_index + 4'd1;
            if (byte_index < 4'd12) begin
              if (rx_byte != expected) header_match_next = 1'b0;
            end else if (byte_index == 4'd12) begin
              inner_length_next = {rx_byte, 8'd0};
            end else begin
              // last header byte: decide forward or skip
              payload_left_next = rest;
              if (header_match && inner_full >= tfd_pkg::HDR_LEN) begin
                inner_length_next = (inner_full > rest) ? rest : inner_full;
                phase_next        = PH_FWD;
              end else begin
                inner_length_next = inner_full;
                phase_next        = (rest == 16'd0) ? PH_IDLE : PH_SKIP;
              end
            end
          end
          PH_FWD: begin
            payload_left_next = left_dec;
            if (inner_length != 16'd0) begin
              inner_length_next = inner_length - 16'd1;
              res_valid         = 1'b1;
              res.kind          = tfd_pkg::KIND_DATA;
              res.payload_byte  = rx_byte;
              res.last          = (inner_length == 16'd1);
            end
            if (left_dec == 16'd0) phase_next = PH_IDLE;
          end
          PH_ERROR: phase_next = PH_ERROR;
          default:  phase_next = PH_ERROR;
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      frame_is_packet <= 1'b0;
      frame_length    <= 16'd0;
      byte_index      <= 4'd0;
      header_match    <= 1'b1;
      inner_length    <= 16'd0;
      payload_left    <= 16'd0;
    end else begin
      phase           <= phase_next;
      frame_is_packet <= frame_is_packet_next;
      frame_length    <= frame_length_next;
      byte_index      <= byte_index_next;
      header_match    <= header_match_next;
      inner_length    <= inner_length_next;
      payload_left    <= payload_left_next;
    end
  end

  // A restart beat returns the parser to idle
  a_restart_idle: assert property (@(posedge clk) disable iff (rst)
    beat && mode |=> phase == PH_IDLE)
    else $error("restart did not return parser to idle");

  // Payload results only come from the forwarding phase
  a_data_in_fwd: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == tfd_pkg::KIND_DATA |-> phase == PH_FWD)
    else $error("payload byte outside forwarding");

  // The error phase holds until a restart
  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR && !(beat && mode) |=> phase == PH_ERROR)
    else $error("error phase left without restart");

  // Forwarding never emits more bytes than the frame has left
  a_fwd_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FWD |-> inner_length <= payload_left)
    else $error("forward count exceeds frame payload");

endmodule

`default_nettype wire

[sv/tfd_outbuf.sv]
// Two-entry result buffer between the parser and the master-side stream.
`default_nettype none

module tfd_outbuf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tfd_pkg::result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tfd_pkg::result_t      out_data
);

  tfd_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[rd_ptr];

  // Store a result beat
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("result buffer overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("result buffer pointers inconsistent");

endmodule

`default_nettype wire

[sv/tunnel_frame_deframer_core.sv]
// Top level of the tunnel frame deframer: config registers, parser and result buffer.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata rx_byte, tuser mode
//  m_*       out        m_tvalid/m_tready  tdata payload_byte, tuser kind, tlast last
//  cfg_*     in         cfg_we             cfg_addr index, cfg_data value
//
// One byte is taken per cycle while s_tready is high; its result, if any, is
// held in the result buffer that drives m_*; the parser's state update sets the rate.
// A two-entry result buffer keeps input flowing while a result waits; s_tready
// falls only while both entries are occupied.
// rst is synchronous: parser goes idle, buffer empties, config returns to defaults.
`default_nettype none

module tunnel_frame_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] payload_byte
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]      protocol_id;
  logic [15:0]      instance_id;
  logic             beat;
  logic             res_valid;
  tfd_pkg::result_t res;
  tfd_pkg::result_t out_data;

  assign beat = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_id <= tfd_pkg::PROTOCOL_ID_RESET;
      instance_id <= tfd_pkg::INSTANCE_ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tfd_pkg::CFG_PROTOCOL_ID: protocol_id <= cfg_data;
        tfd_pkg::CFG_INSTANCE_ID: instance_id <= cfg_data;
        default: ;
      endcase
    end
  end

  tfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .mode        (s_tuser),
    .rx_byte     (s_tdata),
    .protocol_id (protocol_id),
    .instance_id (instance_id),
    .res_valid   (res_valid),
    .res         (res)
  );

  tfd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.payload_byte;
  assign m_tuser = out_data.kind;
  assign m_tlast = out_data.last;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the tunnel frame deframer core.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int ID_BYTES_END  = 12;   // id, offset and size words come before the inner length

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_SKIP, PH_HEADER, PH_FORWARD, PH_HALTED
  } deframe_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_tuser = 1'b0;    // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] payload_byte
  logic [1:0]  m_tuser;           // [1:0] kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  tunnel_frame_deframer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Stream control and bookkeeping
  int               tx_idle_pct = 33;
  int               rx_idle_pct = 33;
  logic             rx_hold = 1'b0;
  int               mismatch_count = 0;
  int               beats_sent = 0;
  int               cycle_count = 0;
  tfd_pkg::result_t pending_results[$];

  // Parser mirror and its copy of the id registers
  logic [15:0]    want_protocol = tfd_pkg::PROTOCOL_ID_RESET;
  logic [15:0]    want_instance = tfd_pkg::INSTANCE_ID_RESET;
  deframe_phase_t dp_phase      = PH_IDLE;
  logic           dp_packet     = 1'b0;
  logic [15:0]    dp_frame_len  = 16'h0000;
  logic [15:0]    dp_hdr_pos    = 16'h0000;
  logic           dp_hdr_ok     = 1'b1;
  logic [15:0]    dp_eth_left   = 16'h0000;
  logic [15:0]    dp_body_left  = 16'h0000;

  // Byte expected at a given position of the inner header
  function automatic logic [7:0] hdr_ref_byte(input logic [15:0] pos);
    case (pos)
      16'd0:                return want_protocol[15:8];
      16'd1:                return want_protocol[7:0];
      16'd2:                return want_instance[15:8];
      16'd3:                return want_instance[7:0];
      16'd7, 16'd9, 16'd11: return tfd_pkg::SLOT_SIZE;
      default:              return 8'h00;
    endcase
  endfunction

  function automatic void start_skip(input logic [15:0] n);
    dp_body_left = n;
    dp_phase = (n == 16'h0000) ? PH_IDLE : PH_SKIP;
  endfunction

  // Queue one expected result beat
  function automatic void expect_beat(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last);
    tfd_pkg::result_t r;
    r.kind = kind;
    r.payload_byte = b;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  // Advance the parser mirror by one accepted beat and queue any result it yields
  function automatic void deframe_predict(input logic restart, input logic [7:0] b);
    logic [15:0] rest;
    if (restart) begin
      dp_phase = PH_IDLE;
      dp_packet = 1'b0;
      dp_frame_len = 16'h0000;
      dp_hdr_pos = 16'h0000;
      dp_hdr_ok = 1'b1;
      dp_eth_left = 16'h0000;
      dp_body_left = 16'h0000;
      return;
    end
    case (dp_phase)
      PH_IDLE: begin
        if (b == tfd_pkg::TYPE_KEEPALIVE || b == tfd_pkg::TYPE_PACKET) begin
          dp_packet = (b == tfd_pkg::TYPE_PACKET);
          dp_phase = PH_LEN_HI;
        end else begin
          dp_phase = PH_HALTED;
          expect_beat(tfd_pkg::KIND_ERROR, 8'h00, 1'b0);
        end
      end
      PH_LEN_HI: begin
        dp_frame_len = {b, 8'h00};
        dp_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        dp_frame_len = dp_frame_len | {8'h00, b};
        if (!dp_packet) begin
          start_skip(dp_frame_len);
          expect_beat(tfd_pkg::KIND_KEEP, 8'h00, 1'b0);
        end else if (dp_frame_len < tfd_pkg::MIN_PACKET) begin
          start_skip(dp_frame_len);
        end else begin
          dp_hdr_pos = 16'h0000;
          dp_hdr_ok = 1'b1;
          dp_eth_left = 16'h0000;
          dp_phase = PH_HEADER;
        end
      end
      PH_SKIP: begin
        dp_body_left = dp_body_left - 16'd1;
        if (dp_body_left == 16'h0000) dp_phase = PH_IDLE;
      end
      PH_HEADER: begin
        if (dp_hdr_pos < ID_BYTES_END) begin
          if (b != hdr_ref_byte(dp_hdr_pos)) dp_hdr_ok = 1'b0;
        end else if (dp_hdr_pos == ID_BYTES_END) begin
          dp_eth_left = {b, 8'h00};
        end else begin
          dp_eth_left = dp_eth_left | {8'h00, b};
        end
        dp_hdr_pos = dp_hdr_pos + 16'd1;
        if (dp_hdr_pos >= tfd_pkg::HDR_LEN) begin
          rest = dp_frame_len - tfd_pkg::HDR_LEN;
          if (dp_hdr_ok && dp_eth_left >= tfd_pkg::HDR_LEN) begin
            // clamp the inner length to what the frame still carries
            if (dp_eth_left > rest) dp_eth_left = rest;
            dp_body_left = rest;
            dp_phase = PH_FORWARD;
          end else begin
            start_skip(rest);
          end
        end
      end
      PH_FORWARD: begin
        dp_body_left = dp_body_left - 16'd1;
        if (dp_eth_left != 16'h0000) begin
          dp_eth_left = dp_eth_left - 16'd1;
          expect_beat(tfd_pkg::KIND_DATA, b, dp_eth_left == 16'h0000);
        end
        if (dp_body_left == 16'h0000) dp_phase = PH_IDLE;
      end
      default: dp_phase = PH_HALTED;
    endcase
  endfunction

  task automatic log_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Receive side: check each beat against the oldest expectation, then pick next ready
  always @(posedge clk) begin : rx_side
    tfd_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected beat kind=%0d byte=%02h last=%0b",
                                 m_tuser, m_tdata, m_tlast));
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.kind)
            log_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
          if (m_tdata !== want.payload_byte)
            log_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.payload_byte));
          if (m_tlast !== want.last)
            log_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic restart, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= restart;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_predict(restart, b);
    beats_sent++;
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ids(input logic [15:0] prot, input logic [15:0] inst);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= tfd_pkg::CFG_PROTOCOL_ID;
    cfg_data <= prot;
    @(posedge clk);
    want_protocol = prot;
    cfg_addr <= tfd_pkg::CFG_INSTANCE_ID;
    cfg_data <= inst;
    @(posedge clk);
    want_instance = inst;
    cfg_we <= 1'b0;
  endtask

  // Payload byte with the extremes over-represented
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Packet frame; bad_pos below zero keeps the header intact, body_cap cuts it short
  task automatic send_pkt_frame(input logic [15:0] flen, input logic [15:0] ilen,
                                input int bad_pos, input int body_cap);
    logic [7:0] hb;
    int         body;
    send_beat(1'b0, tfd_pkg::TYPE_PACKET);
    send_beat(1'b0, flen[15:8]);
    send_beat(1'b0, flen[7:0]);
    body = (int'(flen) < body_cap) ? int'(flen) : body_cap;
    for (int i = 0; i < body; i++) begin
      if (flen >= tfd_pkg::MIN_PACKET && i < ID_BYTES_END) begin
        hb = hdr_ref_byte(16'(i));
        if (i == bad_pos) hb = hb ^ 8'($urandom_range(255, 1));
      end else if (flen >= tfd_pkg::MIN_PACKET && i == ID_BYTES_END) begin
        hb = ilen[15:8];
      end else if (flen >= tfd_pkg::MIN_PACKET && i == ID_BYTES_END + 1) begin
        hb = ilen[7:0];
      end else begin
        hb = pick_byte();
      end
      send_beat(1'b0, hb);
    end
    if (body < int'(flen)) send_beat(1'b1, pick_byte());
  endtask

  task automatic send_ka_frame(input logic [15:0] flen, input int body_cap);
    int body;
    send_beat(1'b0, tfd_pkg::TYPE_KEEPALIVE);
    send_beat(1'b0, flen[15:8]);
    send_beat(1'b0, flen[7:0]);
    body = (int'(flen) < body_cap) ? int'(flen) : body_cap;
    for (int i = 0; i < body; i++) send_beat(1'b0, pick_byte());
    if (body < int'(flen)) send_beat(1'b1, pick_byte());
  endtask

  // Unknown type, some discarded bytes, then restart
  task automatic send_bad_type(input logic [7:0] t, input int junk);
    send_beat(1'b0, t);
    for (int i = 0; i < junk; i++) send_beat(1'b0, pick_byte());
    send_beat(1'b1, pick_byte());
  endtask

  task automatic send_random_frame();
    int         sel;
    int         flen;
    int         ilen;
    logic [7:0] t;
    sel = $urandom_range(99);
    flen = $urandom_range(28, 90);
    ilen = $urandom_range(14, flen - 14);
    if (sel < 55) begin
      case ($urandom_range(9))
        6, 7:    ilen = flen - 14;
        8:       ilen = $urandom_range(flen - 13, 65535);
        default: ;
      endcase
      send_pkt_frame(16'(flen), 16'(ilen), -1, 65536);
    end else if (sel < 64) begin
      send_pkt_frame(16'(flen), 16'(ilen), $urandom_range(0, ID_BYTES_END - 1), 65536);
    end else if (sel < 70) begin
      send_pkt_frame(16'(flen), 16'($urandom_range(0, 13)), -1, 65536);
    end else if (sel < 80) begin
      send_ka_frame(16'($urandom_range(0, 12)), 65536);
    end else if (sel < 86) begin
      send_pkt_frame(16'($urandom_range(0, 27)), 16'h0000, -1, 65536);
    end else if (sel < 92) begin
      do t = 8'($urandom);
      while (t == tfd_pkg::TYPE_KEEPALIVE || t == tfd_pkg::TYPE_PACKET);
      send_bad_type(t, $urandom_range(0, 6));
    end else if (sel < 97) begin
      send_pkt_frame(16'(flen), 16'(ilen), -1, $urandom_range(0, flen - 1));
    end else begin
      send_beat(1'b1, pick_byte());
    end
  endtask

  task automatic run_random_frames(input int n_beats);
    int stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) send_random_frame();
  endtask

  // Reset ids must be in force before any write
  task automatic test_reset_ids();
    send_pkt_frame(16'd28, 16'd14, -1, 65536);
    send_ka_frame(16'd1, 65536);
    wait_idle();
  endtask

  task automatic test_frame_cases();
    send_ka_frame(16'd0, 65536);                      // zero length keepalive
    send_ka_frame(16'd3, 65536);
    send_pkt_frame(16'd0, 16'h0000, -1, 65536);       // zero length short packet
    send_pkt_frame(16'd27, 16'h0000, -1, 65536);      // one below the minimum
    send_pkt_frame(16'd40, 16'd20, -1, 65536);        // forward part, skip the rest
    send_pkt_frame(16'd30, 16'hFFFF, -1, 65536);      // overlong inner length, clamped
    send_pkt_frame(16'd32, 16'd13, -1, 65536);        // inner length too small
    send_pkt_frame(16'd30, 16'd16, 0, 65536);         // id mismatch
    send_pkt_frame(16'd30, 16'd16, 4, 65536);         // offset word mismatch
    send_pkt_frame(16'd30, 16'd16, 11, 65536);        // size word mismatch
    send_bad_type(8'h00, 3);
    send_bad_type(8'h02, 0);
    send_bad_type(8'hFF, 5);
    // restart after the first length byte, and again while idle
    send_beat(1'b0, tfd_pkg::TYPE_PACKET);
    send_beat(1'b0, 8'h00);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    send_pkt_frame(16'd28, 16'd14, -1, 65536);
    wait_idle();
  endtask

  task automatic test_id_extremes();
    set_ids(16'h0000, 16'h0000);
    send_pkt_frame(16'd30, 16'd16, -1, 65536);
    send_pkt_frame(16'd30, 16'd16, 3, 65536);
    set_ids(16'hFFFF, 16'hFFFF);
    send_pkt_frame(16'd30, 16'd16, -1, 65536);
    send_pkt_frame(16'd30, 16'd16, 1, 65536);
    set_ids(16'h0000, 16'hFFFF);
    send_pkt_frame(16'd29, 16'd15, -1, 65536);
    wait_idle();
  endtask

  // Maximum frame lengths, cut short by a restart
  task automatic test_long_frames();
    send_pkt_frame(16'hFFFF, 16'hFFFF, -1, 40);
    send_ka_frame(16'hFFFF, 8);
    send_pkt_frame(16'hFFFF, 16'hFFFF, 2, 20);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    set_ids(16'($urandom), 16'($urandom));
    run_random_frames(60);
    set_ids(16'hFFFF, 16'h0000);
    run_random_frames(50);
    set_ids(16'($urandom), 16'($urandom));
    run_random_frames(60);
    wait_idle();
  endtask

  task automatic test_unbroken_stream();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_frames(150);
    wait_idle();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
  endtask

  // Hold the receiver off while the sender keeps offering, so input stalls
  task automatic test_output_stall();
    tx_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_pkt_frame(16'd60, 16'd46, -1, 65536);
    send_ka_frame(16'd2, 65536);
    send_pkt_frame(16'd50, 16'd30, -1, 65536);
    wait_idle();
    tx_idle_pct = 33;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_ids();
    test_frame_cases();
    test_id_extremes();
    test_long_frames();
    test_random_traffic();
    test_unbroken_stream();
    test_output_stall();
    set_ids(tfd_pkg::PROTOCOL_ID_RESET, tfd_pkg::INSTANCE_ID_RESET);
    send_pkt_frame(16'd28, 16'd14, -1, 65536);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
